// File: design/mbsd_pkg.sv
// Package for the multiplexed BCD stopwatch display.
// Holds digit count, register indexes, payload structs and the segment font.
// No dependencies.
package mbsd_pkg;

  localparam int NUM_DIGITS   = 6;
  localparam int POS_W        = $clog2(NUM_DIGITS);
  localparam int DIGIT_W      = 4;
  localparam int SEG_W        = 8;
  localparam int SLOT_W       = 8;
  localparam int PERIOD_W     = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [POS_W-1:0]       DOT_POSITION    = POS_W'(2);
  localparam logic [SLOT_W-1:0]      SLOT_TICKS_RST  = SLOT_W'(1);
  localparam logic [PERIOD_W-1:0]    COUNT_PERIOD_RST = PERIOD_W'(98);
  localparam logic [PERIOD_W-1:0]    ELAPSED_MAX     = '1;
  localparam logic [DIGIT_W-1:0]     DIGIT_MAX       = DIGIT_W'(9);
  localparam logic [SEG_W-1:0]       SEG_DOT         = 8'h80;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLOT_TICKS   = 1'b0,
    REG_COUNT_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_ticks;
    logic [PERIOD_W-1:0] count_period;
  } cfg_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0] digit_select_n;
    logic [SEG_W-1:0]      segments;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [DIGIT_W-1:0] next_decimal(input logic [DIGIT_W-1:0] d);
    return (d >= DIGIT_MAX) ? '0 : d + DIGIT_W'(1);
  endfunction

endpackage

// File: design/mbsd_ifs.sv
// Stream interfaces for the stopwatch display: tick input and display output.
// Depends on mbsd_pkg for payload widths.
interface mbsd_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface mbsd_disp_if;
  import mbsd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [NUM_DIGITS-1:0] digit_select_n;
  logic [SEG_W-1:0]      segments;

  modport source (output valid, output digit_select_n, output segments, input ready);
  modport sink   (input valid, input digit_select_n, input segments, output ready);
endinterface

// File: design/mbsd_scan.sv
// Scan state of the stopwatch display: digits, position, slot and elapsed counters.
// Computes the result for one beat and the next state. Depends on mbsd_pkg.
module mbsd_scan
  import mbsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  logic    tick,
  output result_t result
);

  logic [DIGIT_W-1:0]  digits [NUM_DIGITS];
  logic [DIGIT_W-1:0]  digits_adv [NUM_DIGITS];
  logic [DIGIT_W-1:0]  digits_next [NUM_DIGITS];
  logic [POS_W-1:0]    pos, pos_next;
  logic [SLOT_W-1:0]   slot_cnt, slot_cnt_next;
  logic [PERIOD_W-1:0] elapsed, elapsed_next, elapsed_base;
  logic                pass_start;
  logic                carry;
  logic                slot_done;
  logic [SEG_W-1:0]    seg;

  always_comb begin
    pass_start = tick && (pos == '0) && (slot_cnt == '0) && (elapsed >= cfg.count_period);
    digits_adv = digits;
    elapsed_base = elapsed;
    carry = 1'b1;
    if (pass_start) begin
      elapsed_base = '0;
      // ripple the cascade from digit 1 upward
      for (int i = 1; i < NUM_DIGITS; i++) begin
        if (carry) begin
          digits_adv[i] = next_decimal(digits[i]);
          carry = (digits_adv[i] == '0);
        end
      end
    end

    seg = seg_font(digits_adv[pos]);
    if (pos == DOT_POSITION) begin
      seg = seg | SEG_DOT;
    end
    result.segments = seg;
    result.digit_select_n = ~(NUM_DIGITS'(1) << pos);

    slot_done = ({1'b0, slot_cnt} + 9'd1) >= {1'b0, cfg.slot_ticks};
    digits_next = digits_adv;
    elapsed_next = (elapsed_base == ELAPSED_MAX) ? elapsed_base
                                                 : elapsed_base + PERIOD_W'(1);
    if (slot_done) begin
      slot_cnt_next = '0;
      pos_next = (pos == POS_W'(NUM_DIGITS - 1)) ? '0 : pos + POS_W'(1);
      if (pos == '0) begin
        digits_next[0] = next_decimal(digits_adv[0]);
      end
    end else begin
      slot_cnt_next = slot_cnt + SLOT_W'(1);
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= '0;
      end
      pos      <= '0;
      slot_cnt <= '0;
      elapsed  <= '0;
    end else if (step && tick) begin
      digits   <= digits_next;
      pos      <= pos_next;
      slot_cnt <= slot_cnt_next;
      elapsed  <= elapsed_next;
    end
  end

endmodule

// File: design/multiplexed_bcd_stopwatch_display_core.sv
// Top level of the multiplexed BCD stopwatch display.
// Depends on mbsd_pkg, mbsd_ifs and mbsd_scan.
//
// Usage:
//   ticks   : input stream, one beat per clock tick (tick=1 means one ms passed,
//             tick=0 gives a result with no state change).
//   display : output stream, exactly one beat per input beat, carrying the
//             active-low digit select and the segment pattern.
//   write_en/write_index/write_data : register writes (0 slot_ticks,
//             1 count_period); write them only while no beat is in flight.
// Output: the result of each accepted input beat is registered into a
//   two-entry output buffer; the scan state is updated by short counter
//   logic and a font lookup. Throughput: one beat per cycle while
//   ticks.ready is high.
// Stall: while the receiver holds ready low the buffer fills; ticks.ready
//   drops only when both entries are occupied, and no beat is lost.
// Reset (synchronous, rst high): digits, position and counters clear, the
//   buffer empties, slot_ticks returns to 1 and count_period to 98.
module multiplexed_bcd_stopwatch_display_core
  import mbsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  mbsd_tick_if.sink              ticks,
  mbsd_disp_if.source            display,
  input  logic                   write_en,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data
);

  cfg_t    cfg;
  result_t result;
  result_t head, spare;
  logic [1:0] count;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_ticks   <= SLOT_TICKS_RST;
      cfg.count_period <= COUNT_PERIOD_RST;
    end else if (write_en) begin
      case (cfg_reg_t'(write_index))
        REG_SLOT_TICKS:   cfg.slot_ticks   <= write_data[SLOT_W-1:0];
        REG_COUNT_PERIOD: cfg.count_period <= write_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign ticks.ready = (count != 2'd2);
  assign push = ticks.valid && ticks.ready;
  assign pop  = display.valid && display.ready;

  mbsd_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (push),
    .tick   (ticks.tick),
    .result (result)
  );

  // Two-entry output buffer: head drives the port, spare holds a stalled beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: if (push) count <= 2'd1;
        2'd1: if (push && !pop) count <= 2'd2;
              else if (!push && pop) count <= 2'd0;
        2'd2: if (pop) count <= 2'd1;
        default: count <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: if (push) head <= result;
      2'd1: begin
        if (push && pop) head <= result;
        else if (push) spare <= result;
      end
      2'd2: if (pop) head <= spare;
      default: ;
    endcase
  end

  assign display.valid          = (count != 2'd0);
  assign display.digit_select_n = head.digit_select_n;
  assign display.segments       = head.segments;

endmodule

// File: verif/tb_top.sv
// Testbench for multiplexed_bcd_stopwatch_display_core: drives tick beats and register writes.
// It predicts each display beat in step and checks it. Depends on mbsd_pkg and mbsd_ifs.
module tb_top;
  import mbsd_pkg::*;

  localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_TICKS     = 138;

  typedef struct packed {
    bit                    is_cfg;
    bit [SLOT_W-1:0]       slot;
    bit [PERIOD_W-1:0]     period;
    bit                    tick;
    bit                    chk;
    bit [NUM_DIGITS-1:0]   sel;
    bit [SEG_W-1:0]        seg;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   write_en;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0]  write_data;

  mbsd_tick_if tk ();
  mbsd_disp_if dp ();

  multiplexed_bcd_stopwatch_display_core uut (
    .clk         (clk),
    .rst         (rst),
    .ticks       (tk),
    .display     (dp),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  // predicted stopwatch state and register copies
  logic [DIGIT_W-1:0]  sw_digit [NUM_DIGITS];
  int                  scan_pos;
  logic [SLOT_W-1:0]   slot_count;
  logic [PERIOD_W-1:0] elapsed;
  logic [SLOT_W-1:0]   cfg_slot;
  logic [PERIOD_W-1:0] cfg_period;

  result_t  shown_q [$];
  dir_row_t directed [28];
  bit       rx_idle = 1'b1;
  bit       hold_long = 1'b0;
  int       errors = 0;
  int       n_ticks = 0;
  int       n_beats = 0;
  int       n_steps = 0;
  int       n_wraps = 0;
  int       n_saturated = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic advance_stopwatch(input bit t, output result_t shown);
    int  i;
    bit  carry_on;
    if (t && scan_pos == 0 && slot_count == '0 && elapsed >= cfg_period) begin
      carry_on = 1'b1;
      for (i = 1; i < NUM_DIGITS; i++) begin
        if (carry_on) begin
          sw_digit[i] = (sw_digit[i] >= 4'd9) ? 4'd0 : sw_digit[i] + 4'd1;
          carry_on = (sw_digit[i] == 4'd0);
        end
      end
      if (carry_on) n_wraps++;
      n_steps++;
      elapsed = '0;
    end
    shown.digit_select_n = '1;
    shown.digit_select_n[scan_pos] = 1'b0;
    shown.segments = (sw_digit[scan_pos] < 4'd10) ? DIGIT_GLYPH[sw_digit[scan_pos]] : 8'h00;
    if (scan_pos == int'(DOT_POSITION)) shown.segments |= SEG_DOT;
    if (t) begin
      if (elapsed < ELAPSED_MAX) elapsed = elapsed + 1'b1;
      else n_saturated++;
      if (int'(slot_count) + 1 >= int'(cfg_slot)) begin
        slot_count = '0;
        if (scan_pos == 0) sw_digit[0] = (sw_digit[0] >= 4'd9) ? 4'd0 : sw_digit[0] + 4'd1;
        scan_pos = (scan_pos + 1 >= NUM_DIGITS) ? 0 : scan_pos + 1;
      end else begin
        slot_count = slot_count + 1'b1;
      end
    end
  endtask

  // Offer one tick beat; keep valid high across back-to-back beats.
  task automatic offer_tick(input bit t, input bit use_typed, input result_t typed, input int gap);
    result_t shown;
    if (gap > 0) begin
      tk.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tk.valid <= 1'b1;
    tk.tick  <= t;
    do @(posedge clk); while (!(tk.valid && tk.ready));
    advance_stopwatch(t, shown);
    shown_q.push_back(use_typed ? typed : shown);
    n_ticks++;
  endtask

  task automatic settle();
    tk.valid <= 1'b0;
    while (shown_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] slot_word,
                             input logic [PERIOD_W-1:0] period);
    write_en    <= 1'b1;
    write_index <= REG_SLOT_TICKS;
    write_data  <= slot_word;
    @(posedge clk);
    cfg_slot = slot_word[SLOT_W-1:0];
    write_index <= REG_COUNT_PERIOD;
    write_data  <= period;
    @(posedge clk);
    cfg_period = period;
    write_en <= 1'b0;
  endtask

  initial begin : stimulus
    int                    k;
    int                    ph;
    int                    waited;
    bit                    tx_idle;
    logic [CFG_DATA_W-1:0] slot_word;
    logic [PERIOD_W-1:0]   period;
    rst         <= 1'b1;
    write_en    <= 1'b0;
    write_index <= REG_SLOT_TICKS;
    write_data  <= '0;
    tk.valid    <= 1'b0;
    tk.tick     <= 1'b0;
    for (k = 0; k < NUM_DIGITS; k++) sw_digit[k] = '0;
    scan_pos   = 0;
    slot_count = '0;
    elapsed    = '0;
    cfg_slot   = SLOT_TICKS_RST;
    cfg_period = COUNT_PERIOD_RST;

    // scan after reset, dot position, idle ticks, zero period, zero slot, extremes
    directed = '{
      '{1'b0, 8'd0,   16'd0,     1'b0, 1'b1, 6'h3E, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h3E, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h3D, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h3B, 8'hBF},
      '{1'b0, 8'd0,   16'd0,     1'b0, 1'b1, 6'h37, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h37, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h2F, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h1F, 8'h3F},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b1, 6'h3E, 8'h06},
      '{1'b1, 8'd1,   16'd0,     1'b0, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b1, 8'd0,   16'd1,     1'b0, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b0, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b1, 8'd255, 16'd65535, 1'b0, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b0, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00},
      '{1'b0, 8'd0,   16'd0,     1'b1, 1'b0, 6'h00, 8'h00}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < $size(directed); k++) begin
      if (directed[k].is_cfg) begin
        settle();
        load_config({8'h00, directed[k].slot}, directed[k].period);
      end else begin
        offer_tick(directed[k].tick, directed[k].chk,
                   result_t'({directed[k].sel, directed[k].seg}), $urandom_range(0, 12));
      end
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       slot_word = 16'd0;
        1:       slot_word = 16'd1;
        2:       slot_word = 16'd255;
        default: slot_word = 16'($urandom_range(1, 4));
      endcase
      slot_word[15:8] = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0:       period = 16'd0;
        1:       period = 16'd1;
        2:       period = 16'hFFFF;
        3:       period = 16'($urandom_range(2, 30));
        default: period = 16'($urandom_range(0, 65535));
      endcase
      if (period > 16'd200 && period != 16'hFFFF) period = period % 16'd200;
      tx_idle = (ph % 3) != 0;
      rx_idle = (ph % 4) != 1;
      // long receiver hold while the sender streams: fill the output buffer
      if (ph == 3) hold_long = 1'b1;
      load_config(slot_word, period);
      for (k = 0; k < PHASE_TICKS; k++)
        offer_tick($urandom_range(0, 3) != 0, 1'b0, '0, tx_idle ? $urandom_range(0, 12) : 0);
    end

    tk.valid <= 1'b0;
    waited = 0;
    while (shown_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (shown_q.size() != 0) begin
      errors += shown_q.size();
      $display("%0t: %0d display beats never arrived", $time, shown_q.size());
    end

    $display("covered %0d tick beats, %0d display beats checked, %0d mismatches",
             n_ticks, n_beats, errors);
    $display("cascade steps %0d, full rollovers %0d, ticks at elapsed ceiling %0d",
             n_steps, n_wraps, n_saturated);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : drain
    int n;
    dp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = rx_idle ? $urandom_range(0, 12) : 0;
      if (hold_long) begin
        n = 120;
        hold_long = 1'b0;
      end
      if (n > 0) begin
        dp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      dp.ready <= 1'b1;
      do @(posedge clk); while (!(dp.valid && dp.ready));
    end
  end

  always @(posedge clk) begin : check_display
    result_t want;
    if (!rst && dp.valid && dp.ready) begin
      n_beats++;
      if (shown_q.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected display beat, expected none, actual %h %h",
                   $time, dp.digit_select_n, dp.segments);
      end else begin
        want = shown_q.pop_front();
        if (dp.digit_select_n !== want.digit_select_n) begin
          errors++;
          if (errors <= 20)
            $display("%0t: digit_select_n expected %h actual %h",
                     $time, want.digit_select_n, dp.digit_select_n);
        end
        if (dp.segments !== want.segments) begin
          errors++;
          if (errors <= 20)
            $display("%0t: segments expected %h actual %h", $time, want.segments, dp.segments);
        end
      end
    end
  end

endmodule
